// ===== design/ipv6_prefix_translation_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prefix translation table checker.
// Each macro expects signals named clk and rst in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef IPV6_PREFIX_TRANSLATION_TABLE_ASSERT_SVH
`define IPV6_PREFIX_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define IPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define IPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipt_pkg
// Types and constants for the IPv6 prefix translation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipt_pkg;

  localparam int ADDR_W = 128;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_ADD       = 2'd0;
  localparam logic [1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [1:0] MODE_REVERT    = 2'd2;

  // Longest prefix; longer lengths saturate to this on add
  localparam logic [7:0] FULL_PREFIX = 8'd128;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] dest_prefix_high;
    logic [63:0] dest_prefix_low;
    logic [7:0]  prefix_length;
    logic [15:0] match_tag;
  } ipt_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        hit;
    logic [3:0]  entry_index;
    logic        accepted;
  } ipt_rsp_t;

  // One stored prefix pair
  typedef struct packed {
    logic [ADDR_W-1:0] src_prefix;
    logic [ADDR_W-1:0] dst_prefix;
    logic [7:0]        prefix_bits;
  } ipt_entry_t;

  // Outcome of checking one entry against an address
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } ipt_match_t;

endpackage

// ===== design/ipv6_prefix_translation_table.sv =====
// ----------------------------------------------------------------------------
// ipv6_prefix_translation_table
// Table of IPv6 prefix pairs: add appends a pair, translate and revert walk
// the stored entries in index order and rewrite the first matching prefix.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | ipt_pkg::ipt_req_t
//  rsp     | out       | rsp_valid/rsp_stall  | ipt_pkg::ipt_rsp_t
//
//  Add and unused-mode items pass from idle to done and out; translate and
//  revert walk the stored entries in index order, one entry read a cycle,
//  each read registered from the memory before it is checked, and stop at
//  the first hit or after the last stored entry. One item is in work at a
//  time; the next is taken while a result waits, and rsp_stall only delays the next result.
//  Synchronous reset empties the table at once (count to zero, no sweep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv6_prefix_translation_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ipt_pkg::ipt_req_t req_item,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ipt_pkg::ipt_rsp_t rsp_item
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                 state;
  logic [CNT_W-1:0]           entries_used;
  logic                       op_reverting;
  logic [ipt_pkg::ADDR_W-1:0] op_addr;
  logic [15:0]                op_tag;
  logic [CNT_W-1:0]           issue_idx;
  logic                       chk_valid;
  logic [IDX_W-1:0]           chk_idx;
  ipt_pkg::ipt_entry_t        rd_entry;
  ipt_pkg::ipt_rsp_t          fin;
  ipt_pkg::ipt_entry_t        entry_mem [TABLE_ENTRIES];

  logic                accept_req;
  logic                room;
  logic                issue_more;
  ipt_pkg::ipt_entry_t new_entry;
  ipt_pkg::ipt_rsp_t   fin_start;
  ipt_pkg::ipt_match_t match;

  assign req_stall  = (state != ST_IDLE);
  assign accept_req = req_valid && !req_stall;
  assign room       = (entries_used < CNT_FULL);
  assign issue_more = (issue_idx < entries_used);

  // Entry built from an add item, length saturated
  always_comb begin
    new_entry.src_prefix  = {req_item.addr_high, req_item.addr_low};
    new_entry.dst_prefix  = {req_item.dest_prefix_high, req_item.dest_prefix_low};
    new_entry.prefix_bits = (req_item.prefix_length > ipt_pkg::FULL_PREFIX) ?
                            ipt_pkg::FULL_PREFIX : req_item.prefix_length;
  end

  // Result fields known at accept: add status, or the pass-through address
  always_comb begin
    fin_start = '0;
    case (req_item.mode)
      ipt_pkg::MODE_ADD: begin
        fin_start.accepted = room;
      end
      ipt_pkg::MODE_TRANSLATE, ipt_pkg::MODE_REVERT: begin
        // filled in by the walk
        fin_start.hit = 1'b0;
      end
      default: begin
        // unused mode: address passes through
        fin_start.result_high = req_item.addr_high;
        fin_start.result_low  = req_item.addr_low;
      end
    endcase
  end

  // Entry memory: writes happen only in idle, reads only while scanning,
  // so the same entry is never read and written in one cycle
  always_ff @(posedge clk) begin
    if (accept_req && (req_item.mode == ipt_pkg::MODE_ADD) && room) begin
      entry_mem[entries_used[IDX_W-1:0]] <= new_entry;
    end
    if ((state == ST_SCAN) && issue_more) begin
      rd_entry <= entry_mem[issue_idx[IDX_W-1:0]];
    end
  end

  ipt_entry_match u_match (
    .entry     (rd_entry),
    .addr      (op_addr),
    .reverting (op_reverting),
    .tag       (op_tag),
    .index     (16'(chk_idx)),
    .result    (match)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entries_used <= '0;
      chk_valid    <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      // a taken result leaves unless a new one replaces it this cycle
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept_req) begin
            op_addr      <= {req_item.addr_high, req_item.addr_low};
            op_reverting <= (req_item.mode == ipt_pkg::MODE_REVERT);
            op_tag       <= req_item.match_tag;
            issue_idx    <= '0;
            chk_valid    <= 1'b0;
            fin          <= fin_start;
            case (req_item.mode)
              ipt_pkg::MODE_ADD: begin
                if (room) begin
                  entries_used <= entries_used + 1'b1;
                end
                state <= ST_DONE;
              end
              ipt_pkg::MODE_TRANSLATE, ipt_pkg::MODE_REVERT: begin
                state <= ST_SCAN;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // issue the next read while checking the previous one
          chk_idx <= issue_idx[IDX_W-1:0];
          if (issue_more) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (chk_valid && match.hit) begin
            fin <= '{result_high: match.addr[127:64],
                     result_low:  match.addr[63:0],
                     hit:         1'b1,
                     entry_index: 4'(chk_idx),
                     accepted:    1'b0};
            chk_valid <= 1'b0;
            state     <= ST_DONE;
          end else begin
            chk_valid <= issue_more;
            if (!chk_valid && !issue_more) begin
              // walked every stored entry without a hit
              fin <= '{result_high: op_addr[127:64],
                       result_low:  op_addr[63:0],
                       hit:         1'b0,
                       entry_index: 4'd0,
                       accepted:    1'b0};
              state <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp_item  <= fin;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ipt_entry_match.sv =====
// ----------------------------------------------------------------------------
// ipt_entry_match
// Compares one table entry against an address and builds the rewritten
// address from the entry's replacement prefix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipt_entry_match (
  input  ipt_pkg::ipt_entry_t         entry,
  input  logic [ipt_pkg::ADDR_W-1:0]  addr,
  input  logic                        reverting,
  input  logic [15:0]                 tag,
  input  logic [15:0]                 index,
  output ipt_pkg::ipt_match_t         result
);

  logic [ipt_pkg::ADDR_W-1:0] mask;
  logic [ipt_pkg::ADDR_W-1:0] key;
  logic [ipt_pkg::ADDR_W-1:0] repl;

  // Top prefix_bits bits set; a shift by the full width leaves all ones
  assign mask = ~({ipt_pkg::ADDR_W{1'b1}} >> entry.prefix_bits);

  // Revert matches on the destination side and restores the source
  assign key  = reverting ? entry.dst_prefix : entry.src_prefix;
  assign repl = reverting ? entry.src_prefix : entry.dst_prefix;

  assign result.hit  = (((addr ^ key) & mask) == '0) && (!reverting || (tag == index));
  assign result.addr = (addr & ~mask) | (repl & mask);

endmodule

// ===== design/ipt_checker.sv =====
// ----------------------------------------------------------------------------
// ipt_checker
// Port-level checks on the prefix translation table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv6_prefix_translation_table_assert.svh"

module ipt_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input ipt_pkg::ipt_rsp_t rsp_item
);

  logic req_taken;
  logic rsp_held;
  logic rsp_miss;
  logic add_clean;

  assign req_taken = req_valid && !req_stall;
  assign rsp_held  = rsp_valid && rsp_stall;
  assign rsp_miss  = rsp_valid && !rsp_item.hit;
  assign add_clean = !rsp_item.hit && (rsp_item.result_high == '0) &&
                     (rsp_item.result_low == '0);

  // the block is busy in the cycle after it accepts an item
  `IPT_ASSERT_NEXT(a_busy_after_accept, req_taken, req_stall, "not busy after accept")

  // a stored add reports no hit and a zero address
  `IPT_ASSERT_NOW(a_add_result, rsp_valid && rsp_item.accepted, add_clean, "add result not clean")

  // a miss reports index zero
  `IPT_ASSERT_NOW(a_miss_index, rsp_miss, rsp_item.entry_index == '0, "index set without hit")

  // a stalled result holds
  `IPT_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_item), "stall not held")

endmodule

bind ipv6_prefix_translation_table ipt_checker u_ipt_checker (.*);
